// ===== rtl/core/ssed_pkg.sv =====
// Package for the slope-sign extrema detector: widths, result kind codes,
// slope codes, the job slot type and the mirrored endpoint value function.
// No dependencies.
`default_nettype none

package ssed_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_BITS    = 32;
  localparam int ADDR_BITS   = 3;
  localparam int SLOTS       = 4;
  localparam int CNT_BITS    = $clog2(SLOTS + 1);
  localparam int IDX_BITS    = $clog2(SLOTS);

  localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 3;
  localparam int Q_BITS    = PROD_BITS - FRAC_BITS;

  localparam logic [FRAC_BITS+1:0] FRAC_ONE = (FRAC_BITS + 2)'(1) << FRAC_BITS;
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
    PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [Q_BITS-1:0] Q_SAT_HI =
    (Q_BITS'(1) << (SAMPLE_BITS - 1)) - Q_BITS'(1);
  localparam logic signed [Q_BITS-1:0] Q_SAT_LO = ~Q_SAT_HI;

  localparam logic KIND_MAX = 1'b0;
  localparam logic KIND_MIN = 1'b1;

  localparam logic [1:0] SLOPE_ZERO = 2'b00;
  localparam logic [1:0] SLOPE_UP   = 2'b01;
  localparam logic [1:0] SLOPE_DOWN = 2'b10;

  localparam logic [ADDR_BITS-1:0] ADDR_VARIATION = '0;

  typedef struct packed {
    logic kind;
    logic cur;     // 1: newest sample, 0: previous sample
    logic mirror;  // 1: mirrored partner value
  } slot_t;

  // e * (1 +/- f), round half up, saturate to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] mirror_value(
    input logic signed [SAMPLE_BITS-1:0] e,
    input logic        [FRAC_BITS-1:0]   f,
    input logic                          plus
  );
    logic        [FRAC_BITS+1:0] k;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] rnd;
    logic signed [Q_BITS-1:0]    q;
    logic signed [SAMPLE_BITS-1:0] r;
    k = plus ? (FRAC_ONE + (FRAC_BITS + 2)'(f)) : (FRAC_ONE - (FRAC_BITS + 2)'(f));
    prod = PROD_BITS'(e) * PROD_BITS'($signed({1'b0, k}));
    rnd = prod + ROUND_HALF;
    q = rnd[PROD_BITS-1:FRAC_BITS];
    if (q > Q_SAT_HI) begin
      r = Q_SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < Q_SAT_LO) begin
      r = Q_SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = q[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slope_sign_extrema_detector.sv =====
// Slope-sign extrema detector: local maxima/minima plus mirrored endpoint
// extrema of a timed sample stream. Single module; uses ssed_pkg.
//
//  channel   direction  handshake             payload
//  input     in         in_valid_i/in_stall_o sample_value_i, sample_time_i, final_sample_i
//  output    out        out_valid_o/out_stall_i extremum_kind_o/value_o/time_o, run_end_o
//  config    in         APB psel/penable      variation_fraction at byte addresses 0 to 3
//
// A sample is classified at its transfer and its results are queued in a job
// register (up to four slots); the output register takes one slot per cycle
// while the output is not stalled; the job register's drain sets the rate. A new
// sample is taken when no slot is queued or as the last queued slot is taken.
// Reset clears all control and record state; variation_fraction resets to 0.
// A stalled output holds the job register and then the input.
`default_nettype none

module slope_sign_extrema_detector
  import ssed_pkg::*;
(
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [ADDR_BITS-1:0]         paddr,
  input  wire  [CFG_BITS-1:0]          pwdata,
  output logic [CFG_BITS-1:0]          prdata,
  output logic                         pready,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  signed [SAMPLE_BITS-1:0] sample_value_i,
  input  wire  [TIME_BITS-1:0]         sample_time_i,
  input  wire                          final_sample_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         extremum_kind_o,
  output logic signed [SAMPLE_BITS-1:0] extremum_value_o,
  output logic [TIME_BITS-1:0]         extremum_time_o,
  output logic                         run_end_o
);

  logic [FRAC_BITS-1:0] variation_q;

  logic signed [SAMPLE_BITS-1:0] prev_value_q;
  logic [TIME_BITS-1:0]          prev_time_q;
  logic [1:0]                    prev_slope_q;
  logic [1:0]                    seen_q;

  logic [CNT_BITS-1:0]           job_cnt_q, job_cnt_d;
  logic [IDX_BITS-1:0]           job_idx_q;
  slot_t                         job_slot_q [SLOTS];
  slot_t                         job_slot_d [SLOTS];
  logic signed [SAMPLE_BITS-1:0] job_pval_q, job_xval_q;
  logic [TIME_BITS-1:0]          job_ptime_q, job_xtime_q;

  logic                          out_valid_q;
  logic                          out_kind_q, out_run_end_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q, out_value_d;
  logic [TIME_BITS-1:0]          out_time_q;

  logic in_xfer, load;
  logic gt, lt, slope_nz;
  logic [1:0] slope;
  logic prev_pos, x_pos;
  logic ep1, ep2, intr_max, intr_min, intr;
  logic ep1_max, ep2_max;
  slot_t head [2];
  slot_t tail [2];
  logic [IDX_BITS-1:0] head_n;
  logic [IDX_BITS-1:0] tail_n;
  logic [IDX_BITS-1:0] rel;
  slot_t cur_slot;
  logic signed [SAMPLE_BITS-1:0] cur_e, cur_mirror;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_BITS-1] == ADDR_VARIATION[ADDR_BITS-1]) ?
                  CFG_BITS'(variation_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variation_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_BITS-1] == ADDR_VARIATION[ADDR_BITS-1]) begin
      variation_q <= pwdata[FRAC_BITS-1:0];
    end
  end

  // classification of the incoming sample
  always_comb begin
    gt       = sample_value_i > prev_value_q;
    lt       = sample_value_i < prev_value_q;
    slope_nz = gt || lt;
    slope    = gt ? SLOPE_UP : (lt ? SLOPE_DOWN : SLOPE_ZERO);
    prev_pos = !prev_value_q[SAMPLE_BITS-1] && (prev_value_q != '0);
    x_pos    = !sample_value_i[SAMPLE_BITS-1] && (sample_value_i != '0);

    ep1      = (seen_q == 2'd1) && slope_nz && (prev_value_q != '0);
    ep1_max  = (gt == prev_pos);
    intr_max = (seen_q == 2'd2) && (prev_slope_q != SLOPE_DOWN) && lt;
    intr_min = (seen_q == 2'd2) && (prev_slope_q != SLOPE_UP) && gt;
    intr     = intr_max || intr_min;
    ep2      = (seen_q != 2'd0) && final_sample_i && slope_nz && (sample_value_i != '0);
    ep2_max  = (gt == x_pos);

    if (ep1) begin
      head[0] = '{kind: ep1_max ? KIND_MAX : KIND_MIN, cur: 1'b0, mirror: 1'b0};
      head[1] = '{kind: ep1_max ? KIND_MIN : KIND_MAX, cur: 1'b0, mirror: 1'b1};
      head_n  = IDX_BITS'(2);
    end else begin
      head[0] = '{kind: intr_max ? KIND_MAX : KIND_MIN, cur: 1'b0, mirror: 1'b0};
      head[1] = head[0];
      head_n  = intr ? IDX_BITS'(1) : IDX_BITS'(0);
    end
    tail[0] = '{kind: ep2_max ? KIND_MAX : KIND_MIN, cur: 1'b1, mirror: 1'b0};
    tail[1] = '{kind: ep2_max ? KIND_MIN : KIND_MAX, cur: 1'b1, mirror: 1'b1};
    tail_n  = ep2 ? IDX_BITS'(2) : IDX_BITS'(0);

    rel = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rel = IDX_BITS'(i) - head_n;
      job_slot_d[i] = (IDX_BITS'(i) < head_n) ? head[i % 2] : tail[rel[0]];
    end
  end

  // slot drain into the output register
  always_comb begin
    cur_slot    = job_slot_q[job_idx_q];
    cur_e       = cur_slot.cur ? job_xval_q : job_pval_q;
    cur_mirror  = mirror_value(cur_e, variation_q, cur_slot.kind == KIND_MAX);
    out_value_d = cur_slot.mirror ? cur_mirror : cur_e;
  end

  assign load       = (job_cnt_q != '0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (job_cnt_q != '0) && !(load && job_cnt_q == CNT_BITS'(1));
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    job_cnt_d = job_cnt_q;
    if (in_xfer) begin
      job_cnt_d = CNT_BITS'(head_n) + CNT_BITS'(tail_n);
    end else if (load) begin
      job_cnt_d = job_cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_value_q <= '0;
      prev_time_q  <= '0;
      prev_slope_q <= SLOPE_ZERO;
      seen_q       <= 2'd0;
      job_cnt_q    <= '0;
      job_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      job_cnt_q <= job_cnt_d;
      if (in_xfer) begin
        job_idx_q <= '0;
        if (final_sample_i) begin
          prev_value_q <= '0;
          prev_time_q  <= '0;
          prev_slope_q <= SLOPE_ZERO;
          seen_q       <= 2'd0;
        end else begin
          prev_value_q <= sample_value_i;
          prev_time_q  <= sample_time_i;
          if (seen_q != 2'd0) begin
            prev_slope_q <= slope;
          end
          if (seen_q != 2'd2) begin
            seen_q <= seen_q + 2'd1;
          end
        end
      end else if (load) begin
        job_idx_q <= job_idx_q + IDX_BITS'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      job_slot_q  <= job_slot_d;
      job_pval_q  <= prev_value_q;
      job_ptime_q <= prev_time_q;
      job_xval_q  <= sample_value_i;
      job_xtime_q <= sample_time_i;
    end
    if (load) begin
      out_kind_q    <= cur_slot.kind;
      out_value_q   <= out_value_d;
      out_time_q    <= cur_slot.cur ? job_xtime_q : job_ptime_q;
      out_run_end_q <= (job_cnt_q == CNT_BITS'(1));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign extremum_kind_o  = out_kind_q;
  assign extremum_value_o = out_value_q;
  assign extremum_time_o  = out_time_q;
  assign run_end_o        = out_run_end_q;

  // checks
  a_job_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_cnt_q <= CNT_BITS'(SLOTS))
    else $error("job slot count out of range");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && final_sample_i |=> seen_q == 2'd0 && prev_slope_q == SLOPE_ZERO)
    else $error("record state not cleared after final sample");

  a_first_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && seen_q == 2'd0 |=> job_cnt_q == '0)
    else $error("first sample of a record queued results");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && job_cnt_q == CNT_BITS'(1) |=> out_valid_o && run_end_o)
    else $error("last slot of a job not marked as run end");

endmodule

`default_nettype wire
